FILE: rtl/arac_pkg.sv
// Shared types and constants of the address range access counter.
`timescale 1ns / 1ps
package arac_pkg;

  localparam int unsigned REGION_COUNT_DEF = 16;
  localparam int unsigned FETCH_INCR       = 4;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_LOAD = 2'd1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_INSTR = 2'd1,
    OP_EVENT = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } bounds_t;

  typedef struct packed {
    logic [63:0] reads;
    logic [63:0] writes;
    logic [63:0] fetches;
    logic [63:0] rd_sum;
    logic [63:0] wr_sum;
    logic [63:0] fe_sum;
  } cnt_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] addr;
    logic [7:0]  size;
  } acc_t;

  typedef struct packed {
    logic [63:0] pc;
    acc_t        a0;
    acc_t        a1;
  } instr_t;

endpackage

FILE: rtl/arac_update.sv
// Region hit test and counter update for one table entry.
`timescale 1ns / 1ps
module arac_update (
  input  arac_pkg::bounds_t bnd_i,
  input  arac_pkg::cnt_t    cnt_i,
  input  arac_pkg::instr_t  ins_i,
  output arac_pkg::cnt_t    cnt_o
);

  logic       hit_pc, hit0, hit1;
  logic       r0, r1, w0, w1;
  logic [1:0] rd_inc, wr_inc;
  logic [8:0] rb_inc, wb_inc;

  always_comb begin
    hit_pc = (bnd_i.lo <= ins_i.pc) && (ins_i.pc < bnd_i.hi);
    hit0   = (ins_i.a0.kind != arac_pkg::KIND_NONE) &&
             (bnd_i.lo <= ins_i.a0.addr) && (ins_i.a0.addr < bnd_i.hi);
    hit1   = (ins_i.a1.kind != arac_pkg::KIND_NONE) &&
             (bnd_i.lo <= ins_i.a1.addr) && (ins_i.a1.addr < bnd_i.hi);
    r0     = hit0 && (ins_i.a0.kind == arac_pkg::KIND_LOAD);
    r1     = hit1 && (ins_i.a1.kind == arac_pkg::KIND_LOAD);
    w0     = hit0 && (ins_i.a0.kind != arac_pkg::KIND_LOAD);
    w1     = hit1 && (ins_i.a1.kind != arac_pkg::KIND_LOAD);
    rd_inc = 2'(r0) + 2'(r1);
    wr_inc = 2'(w0) + 2'(w1);
    rb_inc = (r0 ? 9'(ins_i.a0.size) : 9'd0) + (r1 ? 9'(ins_i.a1.size) : 9'd0);
    wb_inc = (w0 ? 9'(ins_i.a0.size) : 9'd0) + (w1 ? 9'(ins_i.a1.size) : 9'd0);

    cnt_o.reads   = cnt_i.reads + 64'(rd_inc);
    cnt_o.writes  = cnt_i.writes + 64'(wr_inc);
    cnt_o.fetches = cnt_i.fetches + 64'(hit_pc);
    cnt_o.rd_sum  = cnt_i.rd_sum + 64'(rb_inc);
    cnt_o.wr_sum  = cnt_i.wr_sum + 64'(wb_inc);
    cnt_o.fe_sum  = cnt_i.fe_sum +
                    (hit_pc ? 64'(arac_pkg::FETCH_INCR) : 64'd0);
  end

endmodule

FILE: rtl/address_range_access_counter_top.sv
// Top level of the address range access counter: region table, sweep control, response.
//
// Channel   Direction  Handshake             Fields
// command   in         start && !busy        opcode, region_index, region_start, region_end,
//                                            pc, first_*, second_*
// result    out        done_o (one cycle)    out_index, out_valid, six counters
//
// Load and event-only words leave busy low. An instruction word sweeps the table one
// region per cycle through the counter memory's read-modify-write loop: busy stays
// high through ST_SWEEP and ST_DRAIN. A read word passes ST_RESP; done_o is registered from it.
// Reset clears the valid bits and control; unloaded entries read as zero, so no
// clearing pass runs. The receiver cannot stall; results are never held.
`timescale 1ns / 1ps
module address_range_access_counter_top #(
  parameter int unsigned REGION_COUNT = arac_pkg::REGION_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  region_index_i,
  input  logic [63:0] region_start_i,
  input  logic [63:0] region_end_i,
  input  logic [63:0] pc_i,
  input  logic [1:0]  first_kind_i,
  input  logic [63:0] first_addr_i,
  input  logic [7:0]  first_size_i,
  input  logic [1:0]  second_kind_i,
  input  logic [63:0] second_addr_i,
  input  logic [7:0]  second_size_i,
  output logic        done_o,
  output logic [3:0]  out_index_o,
  output logic        out_valid_o,
  output logic [63:0] reads_o,
  output logic [63:0] writes_o,
  output logic [63:0] fetches_o,
  output logic [63:0] read_total_bytes_o,
  output logic [63:0] write_total_bytes_o,
  output logic [63:0] fetch_total_bytes_o
);

  localparam int unsigned IDX_W = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam int unsigned CMP_W = (IDX_W > 4) ? IDX_W + 1 : 5;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REGION_COUNT - 1);

  arac_pkg::state_e state_q, state_d;
  arac_pkg::op_e    op;

  logic              accept, in_range, sweep, ld_we;
  logic [IDX_W-1:0]  in_idx, rd_addr, cnt_q, cnt_d;
  logic [REGION_COUNT-1:0] vld_q;

  logic              wb_vld_q;
  logic [IDX_W-1:0]  wb_idx_q;
  arac_pkg::instr_t  ins_q;

  arac_pkg::bounds_t bnd_mem [REGION_COUNT];
  arac_pkg::cnt_t    cnt_mem [REGION_COUNT];
  arac_pkg::bounds_t bnd_rd_q;
  arac_pkg::cnt_t    cnt_rd_q, cnt_new, cnt_wd;
  logic              cnt_we;
  logic [IDX_W-1:0]  cnt_wa;

  logic              rsp_ok_q;
  logic [3:0]        rsp_idx_q;
  logic              done_q, out_valid_q;
  logic [3:0]        out_index_q;
  arac_pkg::cnt_t    out_cnt_q;

  assign op       = arac_pkg::op_e'(opcode_i);
  assign accept   = start && !busy;
  assign in_idx   = IDX_W'(region_index_i);
  assign in_range = CMP_W'(region_index_i) < CMP_W'(REGION_COUNT);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      arac_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op)
            arac_pkg::OP_INSTR: state_d = arac_pkg::ST_SWEEP;
            arac_pkg::OP_READ:  state_d = arac_pkg::ST_RESP;
            arac_pkg::OP_LOAD,
            arac_pkg::OP_EVENT: state_d = arac_pkg::ST_IDLE;
          endcase
        end
      end
      arac_pkg::ST_SWEEP: begin
        if (cnt_q == LAST_IDX) state_d = arac_pkg::ST_DRAIN;
      end
      arac_pkg::ST_DRAIN: state_d = arac_pkg::ST_IDLE;
      arac_pkg::ST_RESP:  state_d = arac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = (state_q != arac_pkg::ST_IDLE);
    sweep = (state_q == arac_pkg::ST_SWEEP);
    ld_we = accept && (op == arac_pkg::OP_LOAD) && in_range;
    cnt_d = sweep ? cnt_q + IDX_W'(1) : '0;
  end

  assign rd_addr = sweep ? cnt_q : in_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= arac_pkg::ST_IDLE;
      cnt_q    <= '0;
      vld_q    <= '0;
      wb_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      wb_vld_q <= sweep;
      done_q   <= (state_q == arac_pkg::ST_RESP);
      if (ld_we) vld_q[in_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    wb_idx_q <= cnt_q;
    if (accept) begin
      ins_q     <= '{pc: pc_i,
                     a0: '{kind: first_kind_i, addr: first_addr_i, size: first_size_i},
                     a1: '{kind: second_kind_i, addr: second_addr_i, size: second_size_i}};
      rsp_idx_q <= region_index_i;
      rsp_ok_q  <= in_range && vld_q[in_idx];
    end
    if (state_q == arac_pkg::ST_RESP) begin
      out_index_q <= rsp_idx_q;
      out_valid_q <= rsp_ok_q;
      out_cnt_q   <= rsp_ok_q ? cnt_rd_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_we) bnd_mem[in_idx] <= '{lo: region_start_i, hi: region_end_i};
    bnd_rd_q <= bnd_mem[rd_addr];
  end

  arac_update u_update (
    .bnd_i (bnd_rd_q),
    .cnt_i (cnt_rd_q),
    .ins_i (ins_q),
    .cnt_o (cnt_new)
  );

  always_comb begin
    cnt_we = ld_we || (wb_vld_q && vld_q[wb_idx_q]);
    cnt_wa = ld_we ? in_idx : wb_idx_q;
    cnt_wd = ld_we ? '0 : cnt_new;
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd_q <= cnt_mem[rd_addr];
  end

  assign done_o              = done_q;
  assign out_index_o         = out_index_q;
  assign out_valid_o         = out_valid_q;
  assign reads_o             = out_cnt_q.reads;
  assign writes_o            = out_cnt_q.writes;
  assign fetches_o           = out_cnt_q.fetches;
  assign read_total_bytes_o  = out_cnt_q.rd_sum;
  assign write_total_bytes_o = out_cnt_q.wr_sum;
  assign fetch_total_bytes_o = out_cnt_q.fe_sum;

  a_read_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == arac_pkg::OP_READ) |-> ##2 done_o)
    else $error("read word gave no result");

  a_unloaded_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !out_valid_o) |-> (reads_o == '0 && writes_o == '0 && fetches_o == '0))
    else $error("unloaded region returned nonzero counters");

  a_drain_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == arac_pkg::ST_DRAIN) |-> (wb_vld_q && wb_idx_q == LAST_IDX))
    else $error("sweep ended before last region");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result while busy");

  a_no_wb_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_we |-> !wb_vld_q)
    else $error("load collides with sweep write-back");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the address range access counter: directed rows, then random words.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned    REGIONS      = arac_pkg::REGION_COUNT_DEF;
  localparam logic [1:0]     KIND_STORE   = 2'd2;
  localparam logic [1:0]     KIND_ODD     = 2'd3;
  localparam int unsigned    RANDOM_WORDS = 600;
  localparam int unsigned    STALL_LIMIT  = 2000;
  localparam int unsigned    DRAIN_CYCLES = 40;
  localparam int unsigned    REPORT_CAP   = 50;
  localparam logic [63:0]    ALL_ONES     = '1;
  localparam arac_pkg::acc_t NO_ACC       = '0;

  typedef struct packed {
    arac_pkg::op_e     op;
    logic [3:0]        idx;
    arac_pkg::bounds_t span;
    arac_pkg::instr_t  ins;
  } word_t;

  typedef struct packed {
    logic [3:0]     idx;
    logic           vld;
    arac_pkg::cnt_t cnt;
  } snapshot_t;

  typedef struct {
    word_t     w;
    bit        fixed;
    snapshot_t want;
  } row_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start  = 1'b0;
  word_t       cur    = '0;
  logic        busy;
  logic        done_o;
  logic [3:0]  out_index_o;
  logic        out_valid_o;
  logic [63:0] reads_o;
  logic [63:0] writes_o;
  logic [63:0] fetches_o;
  logic [63:0] read_total_bytes_o;
  logic [63:0] write_total_bytes_o;
  logic [63:0] fetch_total_bytes_o;

  bit                loaded  [REGIONS] = '{default: 1'b0};
  arac_pkg::bounds_t spans   [REGIONS] = '{default: '0};
  arac_pkg::cnt_t    tallies [REGIONS] = '{default: '0};
  logic [63:0]       bases   [4];

  snapshot_t   pending_snapshots[$];
  row_t        dir_rows[$];
  string       field_names[8] = '{"out_index", "out_valid", "reads", "writes", "fetches",
                                  "read_total_bytes", "write_total_bytes",
                                  "fetch_total_bytes"};

  bit          idle_on      = 1'b1;
  int          errors       = 0;
  int          stall_cycles = 0;
  int          n_random     = 0;
  int          n_loads      = 0;
  int          n_instrs     = 0;
  int          n_events     = 0;
  int          n_reads      = 0;
  int          n_results    = 0;

  address_range_access_counter_top u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .opcode_i            (cur.op),
    .region_index_i      (cur.idx),
    .region_start_i      (cur.span.lo),
    .region_end_i        (cur.span.hi),
    .pc_i                (cur.ins.pc),
    .first_kind_i        (cur.ins.a0.kind),
    .first_addr_i        (cur.ins.a0.addr),
    .first_size_i        (cur.ins.a0.size),
    .second_kind_i       (cur.ins.a1.kind),
    .second_addr_i       (cur.ins.a1.addr),
    .second_size_i       (cur.ins.a1.size),
    .done_o              (done_o),
    .out_index_o         (out_index_o),
    .out_valid_o         (out_valid_o),
    .reads_o             (reads_o),
    .writes_o            (writes_o),
    .fetches_o           (fetches_o),
    .read_total_bytes_o  (read_total_bytes_o),
    .write_total_bytes_o (write_total_bytes_o),
    .fetch_total_bytes_o (fetch_total_bytes_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= REPORT_CAP) begin
      $display("%0t mismatch in %s: got %h, want %h", $time, what, got, want);
    end
  endtask

  function automatic bit in_span(int r, logic [63:0] addr);
    return spans[r].lo <= addr && addr < spans[r].hi;
  endfunction

  function automatic void tally_access(int r, arac_pkg::acc_t a);
    if (a.kind == arac_pkg::KIND_NONE || !in_span(r, a.addr)) begin
      return;
    end
    if (a.kind == arac_pkg::KIND_LOAD) begin
      tallies[r].reads  += 64'd1;
      tallies[r].rd_sum += 64'(a.size);
    end else begin
      tallies[r].writes += 64'd1;
      tallies[r].wr_sum += 64'(a.size);
    end
  endfunction

  function automatic bit predict_word(word_t w, output snapshot_t s);
    s = '0;
    case (w.op)
      arac_pkg::OP_LOAD: begin
        loaded[w.idx]  = 1'b1;
        spans[w.idx]   = w.span;
        tallies[w.idx] = '0;
      end
      arac_pkg::OP_INSTR: begin
        for (int r = 0; r < REGIONS; r++) begin
          if (loaded[r]) begin
            if (in_span(r, w.ins.pc)) begin
              tallies[r].fetches += 64'd1;
              tallies[r].fe_sum  += 64'(arac_pkg::FETCH_INCR);
            end
            tally_access(r, w.ins.a0);
            tally_access(r, w.ins.a1);
          end
        end
      end
      arac_pkg::OP_READ: begin
        s.idx = w.idx;
        s.vld = loaded[w.idx];
        s.cnt = tallies[w.idx];
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic void queue_row(arac_pkg::op_e op, logic [3:0] idx, logic [63:0] lo,
                                    logic [63:0] hi, logic [63:0] pc, arac_pkg::acc_t a0,
                                    arac_pkg::acc_t a1, bit fixed, logic vld);
    row_t row;
    row.w     = '{op: op, idx: idx, span: '{lo: lo, hi: hi}, ins: '{pc: pc, a0: a0, a1: a1}};
    row.fixed = fixed;
    row.want  = '{idx: idx, vld: vld, cnt: '0};
    dir_rows.push_back(row);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_addr();
    int unsigned r;
    r = $urandom_range(REGIONS - 1);
    case ($urandom_range(5))
      0:       return spans[r].lo - 64'd1;
      1:       return spans[r].lo;
      2:       return spans[r].hi - 64'd1;
      3:       return spans[r].hi;
      4:       return spans[r].lo + 64'($urandom_range(32'h2000));
      default: return rand64();
    endcase
  endfunction

  function automatic arac_pkg::bounds_t pick_span();
    arac_pkg::bounds_t b;
    case ($urandom_range(9))
      0, 1: begin
        b.lo = rand64();
        b.hi = rand64();
      end
      2: begin
        b.lo = 64'($urandom_range(32'hFF));
        b.hi = ALL_ONES - 64'($urandom_range(32'hFF));
      end
      default: begin
        b.lo = bases[$urandom_range(3)] + 64'($urandom_range(32'h3000));
        b.hi = b.lo + 64'($urandom_range(32'h2000));
      end
    endcase
    return b;
  endfunction

  function automatic arac_pkg::acc_t rand_acc();
    arac_pkg::acc_t a;
    a.kind = 2'($urandom_range(3));
    a.addr = pick_addr();
    a.size = 8'($urandom_range(255));
    return a;
  endfunction

  function automatic word_t rand_word();
    word_t       w;
    int unsigned pick;
    pick     = $urandom_range(99);
    w.op     = pick < 12 ? arac_pkg::OP_LOAD  :
               pick < 72 ? arac_pkg::OP_INSTR :
               pick < 77 ? arac_pkg::OP_EVENT : arac_pkg::OP_READ;
    w.idx    = 4'($urandom_range(15));
    w.span   = pick_span();
    w.ins.pc = pick_addr();
    w.ins.a0 = rand_acc();
    w.ins.a1 = rand_acc();
    return w;
  endfunction

  task automatic issue_word(word_t w, bit fixed, snapshot_t want);
    snapshot_t s;
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 33) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    cur   <= w;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    if (predict_word(w, s)) begin
      pending_snapshots.push_back(fixed ? want : s);
    end
    case (w.op)
      arac_pkg::OP_LOAD:  n_loads++;
      arac_pkg::OP_INSTR: n_instrs++;
      arac_pkg::OP_EVENT: n_events++;
      default:            n_reads++;
    endcase
  endtask

  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_snapshots.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    snapshot_t   want;
    logic [63:0] got_f  [8];
    logic [63:0] want_f [8];
    if (rst_ni && done_o) begin
      n_results++;
      if (pending_snapshots.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(out_index_o), '0);
      end else begin
        want   = pending_snapshots.pop_front();
        got_f  = '{64'(out_index_o), 64'(out_valid_o), reads_o, writes_o, fetches_o,
                   read_total_bytes_o, write_total_bytes_o, fetch_total_bytes_o};
        want_f = '{64'(want.idx), 64'(want.vld), want.cnt.reads, want.cnt.writes,
                   want.cnt.fetches, want.cnt.rd_sum, want.cnt.wr_sum,
                   want.cnt.fe_sum};
        for (int k = 0; k < 8; k++) begin
          if (got_f[k] !== want_f[k]) begin
            report_mismatch(field_names[k], got_f[k], want_f[k]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", stall_cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    word_t w;
    bases = '{64'h0, 64'h0000_0000_8000_0000, 64'hFFFF_FFFF_FFFF_8000, rand64()};

    queue_row(arac_pkg::OP_READ,  4'd0,  '0, '0, '0, NO_ACC, NO_ACC, 1'b1, 1'b0);
    queue_row(arac_pkg::OP_READ,  4'd15, '0, '0, '0, NO_ACC, NO_ACC, 1'b1, 1'b0);
    queue_row(arac_pkg::OP_INSTR, 4'd0,  '0, '0, 64'h0,
              '{arac_pkg::KIND_LOAD, 64'h0, 8'd8}, '{KIND_STORE, 64'h0, 8'd8}, 1'b0, 1'b0);
    queue_row(arac_pkg::OP_LOAD,  4'd0,  64'h0, ALL_ONES, '0, NO_ACC, NO_ACC, 1'b0, 1'b0);
    queue_row(arac_pkg::OP_LOAD,  4'd15, 64'h1000, 64'h2000, '0, NO_ACC, NO_ACC, 1'b0, 1'b0);
    queue_row(arac_pkg::OP_LOAD,  4'd1,  64'h5000, 64'h5000, '0, NO_ACC, NO_ACC, 1'b0, 1'b0);
    queue_row(arac_pkg::OP_LOAD,  4'd2,  ALL_ONES, 64'h0, '0, NO_ACC, NO_ACC, 1'b0, 1'b0);
    queue_row(arac_pkg::OP_LOAD,  4'd3,  64'h1800, 64'h3000, '0, NO_ACC, NO_ACC, 1'b0, 1'b0);
    queue_row(arac_pkg::OP_READ,  4'd0,  '0, '0, '0, NO_ACC, NO_ACC, 1'b1, 1'b1);
    queue_row(arac_pkg::OP_INSTR, 4'd0,  '0, '0, 64'h1000,
              '{arac_pkg::KIND_LOAD, 64'h1FFF, 8'd255}, '{KIND_STORE, 64'h2000, 8'd0},
              1'b0, 1'b0);
    queue_row(arac_pkg::OP_INSTR, 4'd0,  '0, '0, ALL_ONES, '{KIND_ODD, 64'h1800, 8'd8},
              '{arac_pkg::KIND_NONE, ALL_ONES, 8'd255}, 1'b0, 1'b0);
    queue_row(arac_pkg::OP_INSTR, 4'd0,  '0, '0, 64'h5000, '{KIND_STORE, 64'h0, 8'd1},
              '{arac_pkg::KIND_LOAD, ALL_ONES - 64'd1, 8'd128}, 1'b0, 1'b0);
    queue_row(arac_pkg::OP_EVENT, 4'd9,  ALL_ONES, ALL_ONES, 64'h1000,
              '{arac_pkg::KIND_LOAD, 64'h1000, 8'd255}, '{KIND_ODD, 64'h1000, 8'd255},
              1'b0, 1'b0);
    queue_row(arac_pkg::OP_READ,  4'd0,  '0, '0, '0, NO_ACC, NO_ACC, 1'b0, 1'b0);
    queue_row(arac_pkg::OP_READ,  4'd1,  '0, '0, '0, NO_ACC, NO_ACC, 1'b0, 1'b0);
    queue_row(arac_pkg::OP_READ,  4'd2,  '0, '0, '0, NO_ACC, NO_ACC, 1'b0, 1'b0);
    queue_row(arac_pkg::OP_READ,  4'd3,  '0, '0, '0, NO_ACC, NO_ACC, 1'b0, 1'b0);
    queue_row(arac_pkg::OP_READ,  4'd15, '0, '0, '0, NO_ACC, NO_ACC, 1'b0, 1'b0);
    queue_row(arac_pkg::OP_LOAD,  4'd3,  64'h1800, 64'h3000, '0, NO_ACC, NO_ACC, 1'b0, 1'b0);
    queue_row(arac_pkg::OP_READ,  4'd3,  '0, '0, '0, NO_ACC, NO_ACC, 1'b1, 1'b1);
    queue_row(arac_pkg::OP_READ,  4'd7,  '0, '0, '0, NO_ACC, NO_ACC, 1'b1, 1'b0);
    queue_row(arac_pkg::OP_INSTR, 4'd0,  '0, '0, 64'h2FFF,
              '{arac_pkg::KIND_LOAD, 64'h17FF, 8'd0}, '{KIND_ODD, 64'h0FFF, 8'd255},
              1'b0, 1'b0);
    queue_row(arac_pkg::OP_READ,  4'd15, '0, '0, '0, NO_ACC, NO_ACC, 1'b0, 1'b0);
    queue_row(arac_pkg::OP_READ,  4'd3,  '0, '0, '0, NO_ACC, NO_ACC, 1'b0, 1'b0);

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      issue_word(dir_rows[i].w, dir_rows[i].fixed, dir_rows[i].want);
    end
    settle();

    while (n_random < RANDOM_WORDS) begin
      w       = rand_word();
      idle_on = !(n_random >= 250 && n_random < 400);
      if (n_random % 200 == 199 && w.op != arac_pkg::OP_EVENT) begin
        settle();
      end
      issue_word(w, 1'b0, '0);
      if (w.op != arac_pkg::OP_EVENT) begin
        n_random++;
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_snapshots.size() != 0) begin
      report_mismatch("results never returned", 64'(pending_snapshots.size()), '0);
    end

    $display("summary: %0d loads, %0d instruction words, %0d ignored events, %0d reads",
             n_loads, n_instrs, n_events, n_reads);
    $display("summary: %0d counter snapshots compared, %0d mismatches", n_results, errors);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
